@@ rtl/mcbd_pkg.sv @@
// Types, codes and sizes shared by the MIDI control binding dispatch block.
// No dependencies; every other file in rtl/ imports this package.
package mcbd_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Item opcodes.
  localparam logic [1:0] OP_MSG        = 2'd0;
  localparam logic [1:0] OP_BIND_BTN   = 2'd1;
  localparam logic [1:0] OP_BIND_FADER = 2'd2;
  localparam logic [1:0] OP_CLEAR      = 2'd3;

  // Status nibbles of the channel-voice messages that matter here.
  localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
  localparam logic [3:0] ST_NOTE_ON   = 4'h9;
  localparam logic [3:0] ST_CTRL      = 4'hB;
  localparam logic [3:0] ST_PROGRAM   = 4'hC;
  localparam logic [3:0] ST_CHAN_PRES = 4'hD;
  localparam logic [3:0] ST_SYSTEM    = 4'hF;

  localparam logic [15:0] FADER_ID_BASE = 16'd128;
  localparam logic [6:0]  LEVEL_FULL    = 7'd127;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_FADER  = 1'b1;

  localparam logic [2:0] ACT_CUE_FLASH    = 3'd0;
  localparam logic [2:0] ACT_CUE_TOGGLE   = 3'd1;
  localparam logic [2:0] ACT_SCENE_GO     = 3'd2;
  localparam logic [2:0] ACT_SCENE_TOGGLE = 3'd3;
  localparam logic [2:0] ACT_MASTER       = 3'd4;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_GO_CUE    = 3'd1;
  localparam logic [2:0] CMD_REL_CUE   = 3'd2;
  localparam logic [2:0] CMD_GO_SCENE  = 3'd3;
  localparam logic [2:0] CMD_REL_SCENE = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  msg_status;
    logic [7:0]  msg_data1;
    logic [7:0]  msg_data2;
    logic [1:0]  msg_length;
    logic [15:0] bind_control_id;
    logic [2:0]  bind_action;
    logic [15:0] bind_target;
    logic [31:0] event_time;
  } in_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] command_target;
    logic [31:0] command_time;
    logic [6:0]  master_level;
    logic        message_accepted;
    logic        table_full;
  } out_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] control_id;
    logic [2:0]  action;
    logic [15:0] target;
  } entry_t;

  // Lookup token that walks down the row of binding cells.
  typedef struct packed {
    logic        lookup;
    logic        kind;
    logic [15:0] id;
    logic        pressed;
    logic [6:0]  fader_level;
    logic [31:0] event_time;
    logic        accepted;
    logic        full;
    logic        found;
    logic [2:0]  cmd;
    logic [15:0] target;
    logic        master_upd;
  } token_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

endpackage

@@ rtl/midi_control_binding_dispatch_core.sv @@
// Top level of the MIDI control binding dispatch block: binding cell row,
// message decode, sequencing and the result register. Depends on mcbd_pkg,
// mcbd_decode and mcbd_cell.

// Every item, bind, clear or MIDI message, yields exactly one result. The
// lookup token of an item walks the row of TABLE_DEPTH binding cells one cell
// per cycle; as it leaves the last cell it is captured in the result register
// and then loaded into the output register, where the result is ready for
// transfer. The input opens again as the result is loaded, so an item is not
// taken while the previous one is still in the cell row; a result that cannot
// leave the output register holds the next one and, through it, the input.
// Binds land in the next free cell at once; the first matching cell in
// insertion order acts and later cells let the token pass. A new item is taken
// as soon as the previous result sits in the output register, even while it
// waits.
module midi_control_binding_dispatch_core
  import mcbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  in_t  req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output out_t rsp
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [6:0]       master_value;
  logic             accept;
  logic             is_bind;
  logic             full;
  logic             do_write;
  entry_t           new_entry;
  token_t           dec_token;
  token_t           result;
  logic             capture;
  logic             load_out;
  logic             head_valid;
  token_t           head_tok;

  logic   tok_valid [0:TABLE_DEPTH];
  token_t tok       [0:TABLE_DEPTH];

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign is_bind   = (req.opcode == OP_BIND_BTN) || (req.opcode == OP_BIND_FADER);
  assign full      = is_bind && (count == CNT_W'(TABLE_DEPTH));
  assign do_write  = accept && is_bind && !full;

  always_comb begin
    new_entry.kind       = (req.opcode == OP_BIND_FADER) ? KIND_FADER : KIND_BUTTON;
    new_entry.control_id = req.bind_control_id;
    new_entry.action     = req.bind_action;
    new_entry.target     = (req.opcode == OP_BIND_FADER) ? 16'd0 : req.bind_target;
  end

  mcbd_decode u_decode (
    .item  (req),
    .full  (full),
    .token (dec_token)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      head_tok <= dec_token;
    end
  end

  assign tok_valid[0] = head_valid;
  assign tok[0]       = head_tok;

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mcbd_cell u_cell (
        .clk           (clk),
        .rst           (rst),
        .index         (CNT_W'(i)),
        .count         (count),
        .wr_en         (do_write && (count == CNT_W'(i))),
        .wr_entry      (new_entry),
        .tok_valid_in  (tok_valid[i]),
        .tok_in        (tok[i]),
        .tok_valid_out (tok_valid[i+1]),
        .tok_out       (tok[i+1])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    capture    = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (tok_valid[TABLE_DEPTH]) begin
          capture    = 1'b1;
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      master_value <= '0;
      rsp_valid    <= 1'b0;
      head_valid   <= 1'b0;
    end else begin
      state      <= state_next;
      head_valid <= accept;
      if (accept && req.opcode == OP_CLEAR) begin
        count <= '0;
      end else if (do_write) begin
        count <= count + CNT_W'(1);
      end
      if (capture && tok[TABLE_DEPTH].master_upd) begin
        master_value <= tok[TABLE_DEPTH].fader_level;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // The cell row keeps recomputing after the token has passed, so the
  // finished token is held here until the output register is free.
  always_ff @(posedge clk) begin
    if (capture) begin
      result <= tok[TABLE_DEPTH];
    end
    if (load_out) begin
      rsp.command          <= result.cmd;
      rsp.command_target   <= result.target;
      rsp.command_time     <= (result.cmd != CMD_NONE) ? result.event_time : 32'd0;
      rsp.master_level     <= master_value;
      rsp.message_accepted <= result.accepted;
      rsp.table_full       <= result.full;
    end
  end

endmodule

@@ rtl/mcbd_decode.sv @@
// Message check and decode: turns an accepted item into a lookup token.
// Depends on mcbd_pkg.
module mcbd_decode
  import mcbd_pkg::*;
(
  input  in_t    item,
  input  logic   full,
  output token_t token
);

  logic [3:0] hi;
  logic [1:0] need;
  logic       ok;
  logic       is_button;
  logic       is_fader;

  always_comb begin
    hi        = item.msg_status[7:4];
    need      = (hi == ST_PROGRAM || hi == ST_CHAN_PRES) ? 2'd2 : 2'd3;
    ok        = (item.opcode == OP_MSG) && (item.msg_length >= 2'd1) &&
                (hi != ST_SYSTEM) && (item.msg_length >= need);
    is_button = (hi == ST_NOTE_OFF) || (hi == ST_NOTE_ON);
    is_fader  = (hi == ST_CTRL);

    token             = '0;
    token.lookup      = ok && (is_button || is_fader);
    token.kind        = is_button ? KIND_BUTTON : KIND_FADER;
    token.id          = is_button ? {8'd0, item.msg_data1}
                                  : FADER_ID_BASE + {8'd0, item.msg_data1};
    token.pressed     = (hi == ST_NOTE_ON) && (item.msg_data2 != 8'd0);
    token.fader_level = item.msg_data2[7] ? LEVEL_FULL : item.msg_data2[6:0];
    token.event_time  = item.event_time;
    token.accepted    = ok;
    token.full        = full;
    token.found       = 1'b0;
    token.cmd         = CMD_NONE;
    token.target      = 16'd0;
    token.master_upd  = 1'b0;
  end

endmodule

@@ rtl/mcbd_cell.sv @@
// One binding cell: holds a table entry and its toggle latch, checks the
// passing lookup token against it and hands the token on. Depends on mcbd_pkg.
module mcbd_cell
  import mcbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] index,
  input  logic [CNT_W-1:0] count,
  input  logic             wr_en,
  input  entry_t           wr_entry,
  input  logic             tok_valid_in,
  input  token_t           tok_in,
  output logic             tok_valid_out,
  output token_t           tok_out
);

  entry_t entry;
  logic   latch;
  logic   hit;
  logic   toggle;
  token_t tok_next;

  always_comb begin
    hit      = tok_valid_in && tok_in.lookup && !tok_in.found && (index < count) &&
               (entry.kind == tok_in.kind) && (entry.control_id == tok_in.id);
    toggle   = 1'b0;
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      if (entry.kind == KIND_BUTTON) begin
        case (entry.action)
          ACT_CUE_FLASH: begin
            tok_next.cmd = tok_in.pressed ? CMD_GO_CUE : CMD_REL_CUE;
          end
          ACT_SCENE_GO: begin
            tok_next.cmd = tok_in.pressed ? CMD_GO_SCENE : CMD_REL_SCENE;
          end
          ACT_CUE_TOGGLE: begin
            if (tok_in.pressed) begin
              toggle       = 1'b1;
              tok_next.cmd = latch ? CMD_REL_CUE : CMD_GO_CUE;
            end
          end
          ACT_SCENE_TOGGLE: begin
            if (tok_in.pressed) begin
              toggle       = 1'b1;
              tok_next.cmd = latch ? CMD_REL_SCENE : CMD_GO_SCENE;
            end
          end
          default: begin
            tok_next.cmd = CMD_NONE;
          end
        endcase
        tok_next.target = (tok_next.cmd != CMD_NONE) ? entry.target : 16'd0;
      end else if (entry.action == ACT_MASTER) begin
        tok_next.master_upd = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
      latch <= 1'b0;
    end else if (toggle) begin
      latch <= !latch;
    end
    tok_out <= tok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid_out <= 1'b0;
    end else begin
      tok_valid_out <= tok_valid_in;
    end
  end

endmodule

@@ tb/sv/tb_midi_control_binding_dispatch_core.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for midi_control_binding_dispatch_core: directed and random
// binds, clears and MIDI messages, checked against a scoreboard that predicts each result.
// Depends on mcbd_pkg and the core itself.

module tb_midi_control_binding_dispatch_core
  import mcbd_pkg::*;
();

  // Status nibbles the package does not name.
  localparam logic [3:0] ST_POLY_PRES  = 4'hA;
  localparam logic [3:0] ST_PITCH_BEND = 4'hE;

  class binding_scoreboard;
    entry_t     rows[TABLE_DEPTH];
    bit         latch[TABLE_DEPTH];
    int         used;
    logic [6:0] master;
    out_t       awaited[$];
    int         mismatches;

    function new();
      used = 0;
      master = '0;
      mismatches = 0;
    endfunction

    function out_t dispatch_item(in_t it);
      out_t        r;
      logic [3:0]  hi;
      int          need;
      bit          found;
      bit          pressed;
      bit          is_btn;
      logic        kind;
      logic [15:0] id;
      r = '0;
      found = 1'b0;
      case (it.opcode)
        OP_BIND_BTN, OP_BIND_FADER: begin
          if (used >= TABLE_DEPTH) begin
            r.table_full = 1'b1;
          end else begin
            rows[used].kind = (it.opcode == OP_BIND_FADER) ? KIND_FADER : KIND_BUTTON;
            rows[used].control_id = it.bind_control_id;
            rows[used].action = it.bind_action;
            rows[used].target = (it.opcode == OP_BIND_FADER) ? 16'd0 : it.bind_target;
            latch[used] = 1'b0;
            used++;
          end
        end
        OP_CLEAR: begin
          used = 0;
        end
        default: begin
          hi = it.msg_status[7:4];
          need = (hi == ST_PROGRAM || hi == ST_CHAN_PRES) ? 2 : 3;
          if (it.msg_length >= 1 && hi != ST_SYSTEM && it.msg_length >= need) begin
            r.message_accepted = 1'b1;
            is_btn = (hi == ST_NOTE_OFF || hi == ST_NOTE_ON);
            pressed = (hi == ST_NOTE_ON) && (it.msg_data2 != 8'd0);
            kind = is_btn ? KIND_BUTTON : KIND_FADER;
            id = is_btn ? {8'h00, it.msg_data1} : FADER_ID_BASE + {8'h00, it.msg_data1};
            if (is_btn || hi == ST_CTRL) begin
              for (int i = 0; i < used && !found; i++) begin
                if (rows[i].kind == kind && rows[i].control_id == id) begin
                  found = 1'b1;
                  if (is_btn) begin
                    if (rows[i].action == ACT_CUE_FLASH) begin
                      r.command = pressed ? CMD_GO_CUE : CMD_REL_CUE;
                    end else if (rows[i].action == ACT_SCENE_GO) begin
                      r.command = pressed ? CMD_GO_SCENE : CMD_REL_SCENE;
                    end else if ((rows[i].action == ACT_CUE_TOGGLE ||
                                  rows[i].action == ACT_SCENE_TOGGLE) && pressed) begin
                      if (rows[i].action == ACT_CUE_TOGGLE)
                        r.command = latch[i] ? CMD_REL_CUE : CMD_GO_CUE;
                      else
                        r.command = latch[i] ? CMD_REL_SCENE : CMD_GO_SCENE;
                      latch[i] = !latch[i];
                    end
                    if (r.command != CMD_NONE) begin
                      r.command_target = rows[i].target;
                      r.command_time = it.event_time;
                    end
                  end else if (rows[i].action == ACT_MASTER) begin
                    master = (it.msg_data2 > 8'd127) ? LEVEL_FULL : it.msg_data2[6:0];
                  end
                end
              end
            end
          end
        end
      endcase
      r.master_level = master;
      return r;
    endfunction

    function void note_item(in_t it);
      awaited = {awaited, dispatch_item(it)};
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: command %0d target %0d",
               got.command, got.command_target);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.command !== want.command) begin
        $error("command: expected %0d, actual %0d", want.command, got.command);
        mismatches++;
      end
      if (got.command_target !== want.command_target) begin
        $error("command_target: expected %0d, actual %0d",
               want.command_target, got.command_target);
        mismatches++;
      end
      if (got.command_time !== want.command_time) begin
        $error("command_time: expected %0d, actual %0d", want.command_time, got.command_time);
        mismatches++;
      end
      if (got.master_level !== want.master_level) begin
        $error("master_level: expected %0d, actual %0d", want.master_level, got.master_level);
        mismatches++;
      end
      if (got.message_accepted !== want.message_accepted) begin
        $error("message_accepted: expected %0d, actual %0d",
               want.message_accepted, got.message_accepted);
        mismatches++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Control ids bound since the last clear, so messages can be aimed at them.
  logic [15:0] btn_ids[$];
  logic [15:0] fdr_ids[$];

  binding_scoreboard sb = new();

  midi_control_binding_dispatch_core DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_result(rsp);
    rsp_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic in_t pack_item(logic [1:0] op, logic [7:0] st, logic [7:0] d1,
                                    logic [7:0] d2, logic [1:0] len, logic [15:0] bid,
                                    logic [2:0] bact, logic [15:0] btgt);
    in_t it;
    it.opcode = op;
    it.msg_status = st;
    it.msg_data1 = d1;
    it.msg_data2 = d2;
    it.msg_length = len;
    it.bind_control_id = bid;
    it.bind_action = bact;
    it.bind_target = btgt;
    it.event_time = $urandom;
    return it;
  endfunction

  function automatic in_t bind_item(bit as_fader);
    logic [15:0] id;
    logic [2:0]  act;
    int          r;
    r = $urandom_range(9);
    if (!as_fader) begin
      id = (r < 7) ? 16'($urandom_range(15)) : (r < 9) ? 16'($urandom_range(255)) :
           16'($urandom);
      act = ($urandom_range(4) == 0) ? 3'($urandom) : 3'($urandom_range(3));
      btn_ids = {btn_ids, id};
      return pack_item(OP_BIND_BTN, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                       id, act, 16'($urandom));
    end
    id = (r < 7) ? FADER_ID_BASE + 16'($urandom_range(7)) :
         (r < 9) ? FADER_ID_BASE + 16'($urandom_range(255)) : 16'($urandom);
    act = ($urandom_range(4) == 0) ? 3'($urandom) : ACT_MASTER;
    fdr_ids = {fdr_ids, id};
    return pack_item(OP_BIND_FADER, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     id, act, 16'($urandom));
  endfunction

  // Mostly binds and messages aimed at bound controls, the rest clears and noise.
  function automatic in_t random_item();
    int          r;
    logic [15:0] id;
    logic [3:0]  ch;
    logic [7:0]  d2;
    logic [1:0]  len;
    r = $urandom_range(999);
    ch = 4'($urandom);
    len = ($urandom_range(9) == 0) ? 2'($urandom) : 2'd3;
    d2 = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom);
    if (r < 15) begin
      btn_ids.delete();
      fdr_ids.delete();
      return pack_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                       16'($urandom), 3'($urandom), 16'($urandom));
    end
    if (r < 195)
      return bind_item(1'b0);
    if (r < 265)
      return bind_item(1'b1);
    if (r < 800 && btn_ids.size() > 0 && (r % 2 == 0 || fdr_ids.size() == 0)) begin
      id = btn_ids[$urandom_range(btn_ids.size() - 1)];
      return pack_item(OP_MSG, {($urandom_range(3) == 0) ? ST_NOTE_OFF : ST_NOTE_ON, ch},
                       id[7:0], d2, len, 16'($urandom), 3'($urandom), 16'($urandom));
    end
    if (r < 800 && fdr_ids.size() > 0) begin
      id = fdr_ids[$urandom_range(fdr_ids.size() - 1)] - FADER_ID_BASE;
      return pack_item(OP_MSG, {ST_CTRL, ch}, id[7:0], d2, len, 16'($urandom),
                       3'($urandom), 16'($urandom));
    end
    return pack_item(OP_MSG, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     16'($urandom), 3'($urandom), 16'($urandom));
  endfunction

  // Offers one item and returns at the edge where its transfer takes place.
  task automatic send_item(input in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    sb.note_item(it);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_t it;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 23;
    recv_stall_pct = 88;

    // Directed: lookup on an empty table, every action, shadowed and meaningless
    // bindings, toggles, releases, saturation, rejects and non-matching messages.
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h0}, 8'd5, 8'd127, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_BIND_BTN, 8'h00, 8'h00, 8'h00, 2'd0, 16'd5, ACT_CUE_FLASH,
                        16'hFFFF));
    send_item(pack_item(OP_BIND_BTN, 8'hFF, 8'hFF, 8'hFF, 2'd3, 16'd6, ACT_CUE_TOGGLE,
                        16'h0001));
    send_item(pack_item(OP_BIND_BTN, 8'h00, 8'h00, 8'h00, 2'd0, 16'd7, ACT_SCENE_GO,
                        16'h1234));
    send_item(pack_item(OP_BIND_BTN, 8'h00, 8'h00, 8'h00, 2'd0, 16'd8, ACT_SCENE_TOGGLE,
                        16'hABCD));
    send_item(pack_item(OP_BIND_FADER, 8'h00, 8'h00, 8'h00, 2'd0, FADER_ID_BASE + 16'd7,
                        ACT_MASTER, 16'hFFFF));
    send_item(pack_item(OP_BIND_BTN, 8'h00, 8'h00, 8'h00, 2'd0, 16'd5, ACT_SCENE_GO,
                        16'h5555));
    send_item(pack_item(OP_BIND_FADER, 8'h00, 8'h00, 8'h00, 2'd0, FADER_ID_BASE + 16'd9,
                        ACT_CUE_FLASH, 16'h0000));
    send_item(pack_item(OP_BIND_BTN, 8'h00, 8'h00, 8'h00, 2'd0, 16'd9, ACT_MASTER,
                        16'h7777));
    it = pack_item(OP_MSG, {ST_NOTE_ON, 4'h0}, 8'd5, 8'd127, 2'd3, 16'd0, 3'd0, 16'd0);
    it.event_time = 32'hFFFF_FFFF;
    send_item(it);
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'hF}, 8'd5, 8'd0, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_OFF, 4'h3}, 8'd7, 8'd64, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h1}, 8'd6, 8'd1, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h1}, 8'd6, 8'd99, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_OFF, 4'h1}, 8'd6, 8'd0, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h2}, 8'd8, 8'd255, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_CTRL, 4'h0}, 8'd7, 8'd255, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_CTRL, 4'h0}, 8'd7, 8'd0, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_CTRL, 4'hF}, 8'd7, 8'd100, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, 8'hF8, 8'd5, 8'd127, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h0}, 8'd5, 8'd127, 2'd2, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h0}, 8'd5, 8'd127, 2'd0, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_PROGRAM, 4'h0}, 8'd5, 8'd0, 2'd1, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_PROGRAM, 4'h3}, 8'd5, 8'd0, 2'd2, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_CHAN_PRES, 4'h4}, 8'd5, 8'd0, 2'd2, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_POLY_PRES, 4'h5}, 8'd5, 8'd9, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_PITCH_BEND, 4'h6}, 8'd5, 8'd9, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_CTRL, 4'h0}, 8'd9, 8'd50, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_MSG, {ST_NOTE_ON, 4'h0}, 8'd9, 8'd50, 2'd3, 16'd0, 3'd0, 16'd0));
    send_item(pack_item(OP_CLEAR, 8'h00, 8'h00, 8'h00, 2'd0, 16'd0, 3'd0, 16'd0));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 88 : 0;
      recv_stall_pct = (ph == 0) ? 88 : (ph == 1) ? 23 : 0;
      // Hold the sender until every result of the previous phase is out.
      drain();
      // Start each phase by overfilling a fresh table.
      btn_ids.delete();
      fdr_ids.delete();
      send_item(pack_item(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                          16'($urandom), 3'($urandom), 16'($urandom)));
      repeat (TABLE_DEPTH + 2) send_item(bind_item($urandom_range(3) == 0));
      repeat (530) send_item(random_item());
    end

    drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
